>>> rtl/stereo_audio_predictive_residual_coder_core_defines.svh
// Assertion macros used by the checker file
`ifndef STEREO_AUDIO_PREDICTIVE_RESIDUAL_CODER_CORE_DEFINES_SVH
`define STEREO_AUDIO_PREDICTIVE_RESIDUAL_CODER_CORE_DEFINES_SVH

// Check a consequence in the same cycle
`define SPR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a consequence in the next cycle
`define SPR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/spr_pkg.sv
`default_nettype none
package spr_pkg;
	localparam int SAMPLE_BITS = 16;
	localparam int MAX_BLOCK   = 4096;
	localparam int CNT_W       = 13;
	localparam int SUM_W       = 28;
	localparam int T_W         = SUM_W + 1;
	localparam int E_W         = 4;
	localparam int DIVR_W      = SUM_W + CNT_W;
	localparam int DV_W        = T_W + 30;
	localparam int DC_W        = 6;
	localparam int Y_W         = 31;
	localparam int PARAM_W     = 16;
	localparam int L_W         = E_W + 16;
	localparam int CFG_W       = 16;

	// register indexes
	localparam logic [1:0] REG_LOSSLESS = 2'd0;
	localparam logic [1:0] REG_QUANT    = 2'd1;
	localparam logic [1:0] REG_INIT     = 2'd2;
	localparam logic [1:0] REG_BLOCK    = 2'd3;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_sample;
		logic signed [SAMPLE_BITS-1:0] right_sample;
	} in_word_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] left_residual;
		logic signed [SAMPLE_BITS-1:0] right_residual;
		logic [PARAM_W-1:0]            golomb_param;
		logic                          param_updated;
	} out_word_t;

	typedef struct packed {
		logic               valid;
		logic [PARAM_W-1:0] m;
	} gol_status_t;
endpackage
`default_nettype wire

>>> rtl/spr_golomb.sv
`default_nettype none
module spr_golomb import spr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [SUM_W-1:0] sum,
	input  wire logic [CNT_W-1:0] count,
	output gol_status_t           status
);
	localparam logic [2:0] G_IDLE = 3'd0;
	localparam logic [2:0] G_EXP  = 3'd1;
	localparam logic [2:0] G_DIV1 = 3'd2;
	localparam logic [2:0] G_SQR  = 3'd3;
	localparam logic [2:0] G_DIV2 = 3'd4;

	logic [2:0]         state_q;
	logic               valid_q;
	logic [PARAM_W-1:0] m_q;
	logic [SUM_W-1:0]   s_q;
	logic [T_W-1:0]     t_q;
	logic [E_W-1:0]     e_q;
	logic [DV_W-1:0]    d_q;
	logic [DIVR_W:0]    rem_q;
	logic [DIVR_W-1:0]  dvs_q;
	logic [DC_W-1:0]    cnt_q;
	logic [Y_W-1:0]     y_q;
	logic [15:0]        frac_q;

	logic [DIVR_W:0]    shl_next;
	logic               exp_more;
	logic [DIVR_W:0]    rem_sh;
	logic               qbit;
	logic [2*Y_W-1:0]   sq;
	logic [L_W-1:0]     l_val;

	// exponent search, divider step, squaring, log word on the last square
	always_comb begin
		shl_next = (DIVR_W+1)'(s_q) << (e_q + E_W'(1));
		exp_more = (shl_next <= (DIVR_W+1)'(t_q)) && (e_q != {E_W{1'b1}});
		rem_sh   = {rem_q[DIVR_W-1:0], d_q[DV_W-1]};
		qbit     = rem_sh >= (DIVR_W+1)'(dvs_q);
		sq       = y_q * y_q;
		l_val    = {e_q, frac_q[14:0], sq[61]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= G_IDLE;
			valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				G_IDLE: begin
					if (start) begin
						valid_q <= 1'b0;
						if (sum == '0) begin
							state_q <= G_IDLE;
							valid_q <= 1'b1;
						end else begin
							state_q <= G_EXP;
						end
					end
				end
				G_EXP: begin
					if (!exp_more) state_q <= G_DIV1;
				end
				G_DIV1: begin
					if (cnt_q == DC_W'(1)) state_q <= G_SQR;
				end
				G_SQR: begin
					if (cnt_q == DC_W'(1) && l_val != '0) begin
						state_q <= G_DIV2;
					end
				end
				G_DIV2: begin
					if (cnt_q == DC_W'(1)) begin
						state_q <= G_IDLE;
						valid_q <= 1'b1;
					end
				end
				default: state_q <= G_IDLE;
			endcase
			// zero log saturates at once
			if (state_q == G_SQR && cnt_q == DC_W'(0)) begin
				state_q <= G_IDLE;
				valid_q <= 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			G_IDLE: begin
				if (start) begin
					s_q <= sum;
					t_q <= T_W'(sum) + T_W'(count);
					e_q <= '0;
					m_q <= '0;
				end
			end
			G_EXP: begin
				if (exp_more) begin
					e_q <= e_q + E_W'(1);
				end else begin
					d_q   <= DV_W'(t_q) << 30;
					dvs_q <= DIVR_W'(s_q) << e_q;
					rem_q <= '0;
					cnt_q <= DC_W'(DV_W);
				end
			end
			G_DIV1, G_DIV2: begin
				rem_q <= qbit ? rem_sh - (DIVR_W+1)'(dvs_q) : rem_sh;
				d_q   <= {d_q[DV_W-2:0], qbit};
				cnt_q <= cnt_q - DC_W'(1);
				if (state_q == G_DIV1 && cnt_q == DC_W'(1)) begin
					y_q    <= {d_q[Y_W-2:0], qbit};
					frac_q <= '0;
					cnt_q  <= DC_W'(16);
				end
				if (state_q == G_DIV2 && cnt_q == DC_W'(1)) begin
					if (d_q[DV_W-2:PARAM_W-1] != '0) m_q <= {PARAM_W{1'b1}};
					else m_q <= {d_q[PARAM_W-2:0], qbit};
				end
			end
			G_SQR: begin
				if (cnt_q == DC_W'(0)) begin
					m_q <= {PARAM_W{1'b1}};
				end else begin
					if (sq[61]) y_q <= sq[61:31];
					else y_q <= sq[60:30];
					frac_q <= {frac_q[14:0], sq[61]};
					cnt_q  <= cnt_q - DC_W'(1);
					if (cnt_q == DC_W'(1)) begin
						if (l_val == '0) begin
							// stay in squaring with a zero count to saturate
							cnt_q <= DC_W'(0);
						end else begin
							d_q   <= DV_W'(21'(65536) + 21'(l_val) - 21'(1));
							dvs_q <= DIVR_W'(l_val);
							rem_q <= '0;
							cnt_q <= DC_W'(DV_W);
						end
					end
				end
			end
			default: ;
		endcase
	end

	assign status.valid = valid_q;
	assign status.m     = m_q;
endmodule
`default_nettype wire

>>> rtl/spr_lane.sv
`default_nettype none
module spr_lane import spr_pkg::*; (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          accept,
	input  wire logic                          close,
	input  wire logic [CNT_W-1:0]              count,
	input  wire logic                          lossless,
	input  wire logic [3:0]                    quant,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	output logic signed [SAMPLE_BITS-1:0]      residual,
	output gol_status_t                        status
);
	localparam int SB = SAMPLE_BITS;

	logic signed [SB-1:0]   h0_q, h1_q, h2_q;
	logic [SUM_W-1:0]       sum_q;
	logic signed [SB+3:0]   s_x, h0_x, h1_x, h2_x, pred, diff;
	logic signed [SB-1:0]   d_ly, r_ly, stored;
	logic [SB-1:0]          mapped;
	logic [SUM_W-1:0]       sum_next;

	// predict, quantize, zigzag map
	always_comb begin
		s_x  = (SB+4)'(sample);
		h0_x = (SB+4)'(h0_q);
		h1_x = (SB+4)'(h1_q);
		h2_x = (SB+4)'(h2_q);
		pred = (h0_x <<< 1) + h0_x - (h1_x <<< 1) - h1_x + h2_x;
		diff = s_x - pred;
		d_ly = sample - h0_q;
		r_ly = d_ly >>> quant;
		if (lossless) begin
			residual = diff[SB-1:0];
			stored   = sample;
		end else begin
			residual = r_ly;
			stored   = h0_q + (r_ly <<< quant);
		end
		mapped   = {residual[SB-2:0], 1'b0} ^ {SB{residual[SB-1]}};
		sum_next = sum_q + SUM_W'(mapped);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h0_q  <= '0;
			h1_q  <= '0;
			h2_q  <= '0;
			sum_q <= '0;
		end else if (accept) begin
			h0_q  <= stored;
			h1_q  <= h0_q;
			h2_q  <= h1_q;
			sum_q <= close ? '0 : sum_next;
		end
	end

	spr_golomb u_golomb (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept & close),
		.sum    (sum_next),
		.count  (count),
		.status (status)
	);
endmodule
`default_nettype wire

>>> rtl/stereo_audio_predictive_residual_coder_core.sv
// Channel  | Handshake          | Payload
// in       | in_valid/in_stall  | in_data   (left_sample, right_sample)
// out      | out_valid/out_stall| out_data  (residuals, golomb_param, param_updated)
// cfg      | cfg_we             | cfg_index, cfg_data
// An accepted frame's result appears in the output register the next cycle.
// A frame that closes a block starts the two per-lane parameter units; input stalls
// until both finish; the wait is set by the serial dividers in each unit.
// Reset loads the config, control and history registers at once; no clearing pass.
`default_nettype none
module stereo_audio_predictive_residual_coder_core import spr_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire in_word_t         in_data,
	output logic                  out_valid,
	input  wire logic             out_stall,
	output out_word_t             out_data,
	input  wire logic             cfg_we,
	input  wire logic [1:0]       cfg_index,
	input  wire logic [CFG_W-1:0] cfg_data
);
	logic               lossless_q;
	logic [3:0]         quant_q;
	logic [PARAM_W-1:0] init_q, param_q;
	logic [CNT_W-1:0]   block_q, fc_q;
	logic               busy_q;
	logic               out_valid_q;
	out_word_t          out_q;

	logic               accept, close;
	logic [CNT_W-1:0]   eff, n;
	logic signed [SAMPLE_BITS-1:0] res_l, res_r;
	gol_status_t        st_l, st_r;
	logic [PARAM_W:0]   m_sum, np;

	// block length clamp, close test, handshake and parameter merge
	always_comb begin
		if (block_q == '0) eff = CNT_W'(1);
		else if (block_q > CNT_W'(MAX_BLOCK)) eff = CNT_W'(MAX_BLOCK);
		else eff = block_q;
		n      = fc_q + CNT_W'(1);
		close  = ({1'b0, fc_q} + (CNT_W+1)'(1)) >= {1'b0, eff};
		in_stall = busy_q | (out_valid_q & out_stall);
		accept = in_valid & ~in_stall;
		m_sum  = (PARAM_W+1)'(st_l.m) + (PARAM_W+1)'(st_r.m);
		np     = (PARAM_W+1)'(m_sum[PARAM_W:1]) + (PARAM_W+1)'(2);
	end

	spr_lane u_lane_l (
		.clk(clk), .arst_n(arst_n), .accept(accept), .close(close), .count(n),
		.lossless(lossless_q), .quant(quant_q), .sample(in_data.left_sample),
		.residual(res_l), .status(st_l)
	);

	spr_lane u_lane_r (
		.clk(clk), .arst_n(arst_n), .accept(accept), .close(close), .count(n),
		.lossless(lossless_q), .quant(quant_q), .sample(in_data.right_sample),
		.residual(res_r), .status(st_r)
	);

	// config, frame count, merge of lane parameters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lossless_q <= 1'b1;
			quant_q    <= '0;
			init_q     <= PARAM_W'(4);
			param_q    <= PARAM_W'(4);
			block_q    <= CNT_W'(1000);
			fc_q       <= '0;
			busy_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_LOSSLESS: lossless_q <= cfg_data[0];
					REG_QUANT:    quant_q    <= cfg_data[3:0];
					REG_INIT: begin
						init_q  <= cfg_data[PARAM_W-1:0];
						param_q <= cfg_data[PARAM_W-1:0];
					end
					REG_BLOCK:    block_q    <= cfg_data[CNT_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				fc_q <= close ? '0 : n;
				if (close) busy_q <= 1'b1;
			end
			if (busy_q && st_l.valid && st_r.valid) begin
				busy_q  <= 1'b0;
				param_q <= np[PARAM_W] ? {PARAM_W{1'b1}} : np[PARAM_W-1:0];
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.left_residual  <= res_l;
			out_q.right_residual <= res_r;
			out_q.golomb_param   <= param_q;
			out_q.param_updated  <= close;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	logic unused_init;
	assign unused_init = ^init_q;
endmodule
`default_nettype wire

>>> rtl/spr_checker.sv
`default_nettype none
`include "stereo_audio_predictive_residual_coder_core_defines.svh"
module spr_checker import spr_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_stall,
	input wire in_word_t         in_data,
	input wire logic             out_valid,
	input wire logic             out_stall,
	input wire out_word_t        out_data,
	input wire logic             cfg_we,
	input wire logic [1:0]       cfg_index,
	input wire logic [CFG_W-1:0] cfg_data
);
	// hold a stalled result
	`SPR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "word lost")
	// every accepted frame yields a word next cycle
	`SPR_ASSERT_NEXT(a_in_to_out, in_valid && !in_stall, out_valid, "no result word")
	// never take a frame while a result is blocked
	`SPR_ASSERT_NOW(a_back_press, out_valid && out_stall, in_stall, "input over blocked word")
	// a closing frame stalls the input while its word is out
	`SPR_ASSERT_NEXT(a_recompute, in_valid && !in_stall, !out_data.param_updated || in_stall, "no stall")
endmodule

bind stereo_audio_predictive_residual_coder_core spr_checker u_spr_checker (.*);
`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
	import spr_pkg::*;

	localparam int LIMIT_CYCLES = 2000000;
	localparam int SETTLE = 200;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_word_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_word_t out_data;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = REG_LOSSLESS;
	logic [CFG_W-1:0] cfg_data = '0;

	stereo_audio_predictive_residual_coder_core dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// coder state as predicted
	logic lossless_q;
	logic [3:0] shift_q;
	logic [15:0] start_param_q;
	logic [12:0] block_len_q;
	logic signed [15:0] hist [2][3];
	longint unsigned zig_sum [2];
	int unsigned frames_in_block;
	logic [15:0] param_now;

	out_word_t pending_words[$];
	int fails = 0;
	int unsigned cycles = 0;
	bit calm = 0;
	int hold_left = 0;
	logic signed [15:0] walk [2];

	initial begin
		forever #1 clk = ~clk;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("tb: failure");
			$finish;
		end
	end

	// receiver: random stall, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!calm && $urandom_range(99) < 13) begin
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// compare each accepted result word with the oldest prediction
	always @(posedge clk) begin
		out_word_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_words.size() == 0) begin
				$error("unexpected result word %h", out_data);
				fails++;
			end else begin
				want = pending_words.pop_front();
				if (out_data.left_residual !== want.left_residual) begin
					$error("left_residual exp %0d got %0d", want.left_residual,
						out_data.left_residual);
					fails++;
				end
				if (out_data.right_residual !== want.right_residual) begin
					$error("right_residual exp %0d got %0d", want.right_residual,
						out_data.right_residual);
					fails++;
				end
				if (out_data.golomb_param !== want.golomb_param) begin
					$error("golomb_param exp %0d got %0d", want.golomb_param,
						out_data.golomb_param);
					fails++;
				end
				if (out_data.param_updated !== want.param_updated) begin
					$error("param_updated exp %0d got %0d", want.param_updated,
						out_data.param_updated);
					fails++;
				end
			end
		end
	end

	// residual of one lane; advance its history and mapped sum
	function automatic logic signed [15:0] lane_residual(int ch, logic signed [15:0] x);
		int pred;
		logic signed [15:0] r;
		logic signed [15:0] diff;
		logic [15:0] rebuilt;
		if (lossless_q) begin
			pred = 3 * int'(hist[ch][0]) - 3 * int'(hist[ch][1]) + int'(hist[ch][2]);
			r = 16'(int'(x) - pred);
			rebuilt = x;
		end else begin
			diff = x - hist[ch][0];
			r = diff >>> shift_q;
			rebuilt = hist[ch][0] + (r << shift_q);
		end
		hist[ch][2] = hist[ch][1];
		hist[ch][1] = hist[ch][0];
		hist[ch][0] = rebuilt;
		zig_sum[ch] += (r < 0) ? longint'(-2 * int'(r) - 1) : longint'(2 * int'(r));
		return r;
	endfunction

	// Golomb m from a mapped sum and the frames in the block
	function automatic longint unsigned golomb_m(longint unsigned s, longint unsigned n);
		longint unsigned t, y, l, frac, m;
		int e;
		frac = 0;
		e = 0;
		if (s == 0)
			return 0;
		t = s + n;
		while (e < 40 && (s << (e + 1)) <= t)
			e++;
		y = (t << 30) / (s << e);
		for (int i = 15; i >= 0; i--) begin
			y = (y * y) >> 30;
			if (y >= (64'd1 << 31)) begin
				y >>= 1;
				frac |= 64'd1 << i;
			end
		end
		l = (longint'(e) << 16) | frac;
		if (l == 0)
			return 65535;
		m = (65536 + l - 1) / l;
		return (m > 65535) ? 65535 : m;
	endfunction

	function automatic out_word_t code_frame(in_word_t w);
		out_word_t o;
		int unsigned eff;
		longint unsigned np;
		eff = (block_len_q == 0) ? 1 : (block_len_q > MAX_BLOCK ? MAX_BLOCK : block_len_q);
		o.left_residual = lane_residual(0, w.left_sample);
		o.right_residual = lane_residual(1, w.right_sample);
		o.golomb_param = param_now;
		o.param_updated = 1'b0;
		if (frames_in_block + 1 >= eff) begin
			np = (golomb_m(zig_sum[0], frames_in_block + 1)
				+ golomb_m(zig_sum[1], frames_in_block + 1)) / 2 + 2;
			param_now = (np > 65535) ? 16'hFFFF : 16'(np);
			zig_sum[0] = 0;
			zig_sum[1] = 0;
			frames_in_block = 0;
			o.param_updated = 1'b1;
		end else begin
			frames_in_block = (frames_in_block + 1) & 13'h1FFF;
		end
		return o;
	endfunction

	task automatic send_frame(in_word_t w);
		int gap;
		out_word_t exp_word;
		gap = 0;
		if (!calm)
			while ($urandom_range(99) < 13)
				gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (in_stall);
		exp_word = code_frame(w);
		pending_words = {pending_words, exp_word};
	endtask

	// pause input until every predicted word has come back
	task automatic drain();
		in_valid <= 1'b0;
		wait (pending_words.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LOSSLESS: lossless_q = val[0];
			REG_QUANT: shift_q = val[3:0];
			REG_INIT: begin
				start_param_q = val;
				param_now = val;
			end
			REG_BLOCK: block_len_q = val[12:0];
			default: ;
		endcase
	endtask

	function automatic in_word_t pair(int l, int r);
		in_word_t w;
		w.left_sample = 16'(l);
		w.right_sample = 16'(r);
		return w;
	endfunction

	// smooth audio-like walk, with some full-range noise
	function automatic in_word_t next_frame(bit noisy);
		if (noisy || $urandom_range(19) == 0)
			return pair($urandom, $urandom);
		for (int c = 0; c < 2; c++)
			walk[c] = walk[c] + 16'($signed($urandom_range(64)) - 32);
		return pair(walk[0], walk[1]);
	endfunction

	task automatic test_extremes();
		int vals [8] = '{32767, -32768, 0, -1, 1, 32767, -32768, 21845};
		write_reg(REG_BLOCK, 1);
		foreach (vals[i])
			send_frame(pair(vals[i], vals[7 - i]));
		write_reg(REG_BLOCK, 4);
		repeat (6) send_frame(pair(32767, -32768));
	endtask

	task automatic test_lossy();
		write_reg(REG_LOSSLESS, 0);
		write_reg(REG_QUANT, 15);
		repeat (4) send_frame(pair($urandom, $urandom));
		write_reg(REG_QUANT, 0);
		send_frame(pair(-32768, 32767));
		send_frame(pair(32767, -32768));
		write_reg(REG_QUANT, 7);
		repeat (4) send_frame(pair($urandom, $urandom));
		write_reg(REG_LOSSLESS, 1);
	endtask

	task automatic test_block_edges();
		// out-of-range lengths, then lower the length mid-block
		write_reg(REG_INIT, 0);
		write_reg(REG_BLOCK, 0);
		send_frame(pair(5, -5));
		write_reg(REG_BLOCK, 8191);
		repeat (5) send_frame(pair(100, -100));
		write_reg(REG_BLOCK, 3);
		send_frame(pair(0, 0));
		write_reg(REG_INIT, 65535);
		write_reg(REG_BLOCK, 2);
		repeat (3) send_frame(pair(0, 0));
	endtask

	task automatic test_random(int count);
		int done;
		done = 0;
		while (done < count) begin
			write_reg(REG_LOSSLESS, $urandom_range(1));
			write_reg(REG_QUANT, $urandom_range(15));
			write_reg(REG_INIT, ($urandom_range(3) == 0) ? $urandom : $urandom_range(1, 40));
			write_reg(REG_BLOCK, ($urandom_range(9) == 0) ? $urandom_range(50, 120)
				: $urandom_range(1, 16));
			calm = ($urandom_range(5) == 0);
			for (int i = 0; i < 60; i++) begin
				send_frame(next_frame($urandom_range(4) == 0));
				done++;
			end
			calm = 0;
		end
	endtask

	task automatic test_backpressure();
		write_reg(REG_BLOCK, 5);
		hold_left = 400;
		repeat (30) send_frame(next_frame(0));
		drain();
		repeat (10) send_frame(next_frame(1));
	endtask

	initial begin
		lossless_q = 1'b1;
		shift_q = '0;
		start_param_q = 16'd4;
		block_len_q = 13'd1000;
		param_now = 16'd4;
		frames_in_block = 0;
		zig_sum[0] = 0;
		zig_sum[1] = 0;
		walk[0] = '0;
		walk[1] = '0;
		for (int c = 0; c < 2; c++)
			for (int k = 0; k < 3; k++)
				hist[c][k] = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// defaults straight out of reset
		repeat (5) send_frame(next_frame(1));
		test_extremes();
		test_lossy();
		test_block_edges();
		test_backpressure();
		test_random(600);
		drain();
		if (fails == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

>>> files.f
+incdir+rtl
rtl/spr_pkg.sv
rtl/spr_golomb.sv
rtl/spr_lane.sv
rtl/stereo_audio_predictive_residual_coder_core.sv
rtl/spr_checker.sv
tb/tb_top.sv
